[sv/rrsd_pkg.sv]
`timescale 1ns / 1ps

package rrsd_pkg;

    localparam int NUM_SERVERS = 16;
    localparam int IDX_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int SID_W       = 6;
    localparam int NSRV_W      = 7;
    localparam int TIME_W      = 32;
    localparam int FIN_W       = TIME_W + 1;
    localparam int CNT_W       = 32;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;

    localparam logic [NSRV_W-1:0] NSRV_RESET = NSRV_W'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_PICK,
        ST_DISP,
        ST_MAX,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic free_calc;
        logic pick_calc;
        logic disp_commit;
        logic max_step;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

[sv/rrsd_ctrl.sv]
`timescale 1ns / 1ps

module rrsd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_mode,
    output logic          in_ready,
    output rrsd_pkg::cmd_t  cmd,
    input  rrsd_pkg::stat_t stat
);
    import rrsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = in_mode ? ST_MAX : ST_FREE;
                end
            end
            ST_FREE:
            begin
                cmd.free_calc = 1'b1;
                state_next    = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick_calc = 1'b1;
                state_next    = ST_DISP;
            end
            ST_DISP:
            begin
                if (stat.out_free)
                begin
                    cmd.disp_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_MAX:
            begin
                cmd.max_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!stat.hit || stat.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/rrsd_dp.sv]
`timescale 1ns / 1ps

module rrsd_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rrsd_pkg::cmd_t                 cmd,
    output rrsd_pkg::stat_t                stat,
    input  logic                           cfg_we,
    input  logic [rrsd_pkg::NSRV_W-1:0]    cfg_wdata,
    input  logic                           in_mode,
    input  logic [rrsd_pkg::TIME_W-1:0]    in_arrival,
    input  logic [rrsd_pkg::TIME_W-1:0]    in_load,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rrsd_pkg::SID_W-1:0]     out_id,
    output logic                           out_acc,
    output logic                           out_rep,
    output logic [rrsd_pkg::CNT_W-1:0]     out_cnt,
    output logic                           out_last
);
    import rrsd_pkg::*;

    logic [NSRV_W-1:0]      nsrv_reg;
    logic [FIN_W-1:0]       busy_reg [NUM_SERVERS];
    logic [CNT_W-1:0]       cnt_reg  [NUM_SERVERS];
    logic [SID_W-1:0]       start_reg;

    logic                   mode_reg;
    logic [TIME_W-1:0]      t_reg;
    logic [TIME_W-1:0]      load_reg;
    logic [IDX_W-1:0]       kmax_reg;
    logic [NUM_SERVERS-1:0] free_reg;
    logic [IDX_W-1:0]       pick_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       best_reg;
    logic [IDX_W-1:0]       lastid_reg;

    logic                   out_valid_reg;
    logic [SID_W-1:0]       out_id_reg;
    logic                   out_acc_reg;
    logic                   out_rep_reg;
    logic [CNT_W-1:0]       out_cnt_reg;
    logic                   out_last_reg;

    logic [IDX_W-1:0]       kmax_next;
    logic [NUM_SERVERS-1:0] free_next;
    logic [IDX_W-1:0]       start_eff;
    logic [IDX_W-1:0]       start_next;
    logic [IDX_W-1:0]       pick_hi;
    logic [IDX_W-1:0]       pick_lo;
    logic                   hi_any;
    logic [IDX_W-1:0]       rd_idx;
    logic [CNT_W-1:0]       cnt_rd;
    logic [CNT_W-1:0]       cnt_inc;
    logic [FIN_W-1:0]       fin_next;
    logic                   out_free;
    logic                   hit;
    logic                   idx_last;
    logic                   emit_load;

    always_comb
    begin
        if (nsrv_reg == '0)
        begin
            kmax_next = '0;
        end
        else if (nsrv_reg > NSRV_W'(NUM_SERVERS))
        begin
            kmax_next = IDX_W'(NUM_SERVERS - 1);
        end
        else
        begin
            kmax_next = IDX_W'(nsrv_reg - NSRV_W'(1));
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            free_next[i] = (busy_reg[i] <= {1'b0, t_reg}) && (IDX_W'(i) <= kmax_reg);
        end
    end

    always_comb
    begin
        start_eff = (start_reg <= SID_W'(kmax_reg)) ? IDX_W'(start_reg) : '0;
        start_next = (start_eff == kmax_reg) ? '0 : start_eff + IDX_W'(1);
        pick_hi = '0;
        pick_lo = '0;
        hi_any  = 1'b0;
        for (int i = NUM_SERVERS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                pick_lo = IDX_W'(i);
                if (IDX_W'(i) >= start_eff)
                begin
                    pick_hi = IDX_W'(i);
                    hi_any  = 1'b1;
                end
            end
        end
    end

    assign rd_idx    = mode_reg ? idx_reg : pick_reg;
    assign cnt_rd    = cnt_reg[rd_idx];
    assign cnt_inc   = (cnt_rd == '1) ? cnt_rd : cnt_rd + CNT_W'(1);
    assign fin_next  = {1'b0, t_reg} + {1'b0, load_reg};
    assign out_free  = !out_valid_reg || out_ready;
    assign hit       = (cnt_rd == best_reg);
    assign idx_last  = (idx_reg == kmax_reg);
    assign emit_load = cmd.emit_step && hit;

    assign stat.idx_last = idx_last;
    assign stat.hit      = hit;
    assign stat.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsrv_reg  <= NSRV_RESET;
            start_reg <= '0;
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                busy_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                nsrv_reg <= cfg_wdata;
            end
            if (cmd.pick_calc)
            begin
                start_reg <= SID_W'(start_next);
            end
            if (cmd.disp_commit && found_reg)
            begin
                busy_reg[pick_reg] <= fin_next;
                cnt_reg[pick_reg]  <= cnt_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= in_mode;
            t_reg      <= in_arrival;
            load_reg   <= in_load;
            kmax_reg   <= kmax_next;
            idx_reg    <= '0;
            best_reg   <= '0;
            lastid_reg <= '0;
        end
        if (cmd.free_calc)
        begin
            free_reg <= free_next;
        end
        if (cmd.pick_calc)
        begin
            pick_reg  <= hi_any ? pick_hi : pick_lo;
            found_reg <= |free_reg;
        end
        if (cmd.max_step)
        begin
            if (cnt_rd > best_reg)
            begin
                best_reg   <= cnt_rd;
                lastid_reg <= idx_reg;
            end
            else if (cnt_rd == best_reg)
            begin
                lastid_reg <= idx_reg;
            end
        end
        if (cmd.max_step || cmd.emit_step)
        begin
            idx_reg <= idx_last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.disp_commit || emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.disp_commit)
        begin
            out_id_reg   <= found_reg ? SID_W'(pick_reg) : '0;
            out_acc_reg  <= found_reg;
            out_rep_reg  <= 1'b0;
            out_cnt_reg  <= found_reg ? cnt_inc : '0;
            out_last_reg <= 1'b1;
        end
        else if (emit_load)
        begin
            out_id_reg   <= SID_W'(idx_reg);
            out_acc_reg  <= 1'b1;
            out_rep_reg  <= 1'b1;
            out_cnt_reg  <= best_reg;
            out_last_reg <= (idx_reg == lastid_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_acc   = out_acc_reg;
    assign out_rep   = out_rep_reg;
    assign out_cnt   = out_cnt_reg;
    assign out_last  = out_last_reg;

endmodule

[sv/round_robin_server_dispatch.sv]
`timescale 1ns / 1ps
// Round-robin dispatcher over a bank of servers with per-server finish times.
// Input stream (s_axis): tuser carries the mode (0 dispatch, 1 report); tdata
// carries arrival_time in bits 31:0 and load_time in bits 63:32.
// Output stream (m_axis): tdata carries server_id, accepted and busiest_count;
// tuser marks a report beat; tlast marks the final beat caused by one input.
// cfg_we/cfg_wdata set the number of servers in use; write only while idle.
// After accept, a dispatch runs the parallel free compare, then the rotating
// priority encoder, then commits the chosen server and loads the output
// register once it is free. The next input is taken in the cycle after the
// result is loaded, so no new input is taken while a dispatch is in progress.
// A report scans the servers in use twice (max pass, emit pass), one per
// cycle except that the emit pass stalls on a matching server while the output
// register is full; the next input is taken in the cycle after the emit pass ends.
// Reset clears all finish times, counts and the start index, and sets the
// server count to 16. When m_axis_tready is low the result beat is held in
// the output register and the block waits before loading the next one.
module round_robin_server_dispatch (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rrsd_pkg::NSRV_W-1:0]          cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rrsd_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // arrival_time, load_time
    input  logic                                 s_axis_tuser,  // mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rrsd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // server_id, accepted,
                                                                // busiest_count, pad
    output logic                                 m_axis_tuser,  // is_report
    output logic                                 m_axis_tlast
);
    import rrsd_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [SID_W-1:0]  out_id;
    logic              out_acc;
    logic [CNT_W-1:0]  out_cnt;

    rrsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rrsd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_mode    (s_axis_tuser),
        .in_arrival (s_axis_tdata[TIME_W-1:0]),
        .in_load    (s_axis_tdata[2*TIME_W-1:TIME_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_id     (out_id),
        .out_acc    (out_acc),
        .out_rep    (m_axis_tuser),
        .out_cnt    (out_cnt),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_cnt, out_acc, out_id};

endmodule
